// ===== rtl/biobtp_pkg.sv =====
// Shared types, codes and a helper function of the board I/O blitter trackball port.
package biobtp_pkg;

    // Item kinds.
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;
    localparam logic [1:0] REQ_LOAD  = 2'd3;

    // Bus addresses.
    localparam logic [15:0] ADDR_ROM_FILL = 16'h0000;
    localparam logic [15:0] ADDR_ROM_INC  = 16'h0004;
    localparam logic [15:0] ADDR_PTR_HI   = 16'h0008;
    localparam logic [15:0] ADDR_PTR_MID  = 16'h0017;
    localparam logic [15:0] ADDR_PTR_LO   = 16'h0018;
    localparam logic [15:0] ADDR_ROW      = 16'h4000;
    localparam logic [15:0] ADDR_BANK     = 16'h4800;
    localparam logic [15:0] ADDR_LATCH    = 16'h6000;
    localparam logic [15:0] ADDR_WDOG     = 16'h6800;
    localparam logic [15:0] ADDR_PORT0    = 16'h7000;
    localparam logic [15:0] ADDR_PORT1    = 16'h7800;

    // Configuration register indexes.
    localparam logic [1:0] CFG_VARIANT = 2'd0;
    localparam logic [1:0] CFG_CABINET = 2'd1;
    localparam logic [1:0] CFG_WDLIMIT = 2'd2;

    // Where the read byte of a result comes from.
    localparam logic [1:0] RD_DIRECT = 2'd0;
    localparam logic [1:0] RD_ROM    = 2'd1;
    localparam logic [1:0] RD_FILL   = 2'd2;

    localparam logic [7:0] P0_MASK = 8'hb0;
    localparam logic [7:0] P1_MASK = 8'hf0;

    typedef struct packed {
        logic [1:0] rd_src;
        logic [7:0] rd_byte;
        logic [7:0] latch;
        logic       irq;
        logic [2:0] bank;
        logic       bank_ok;
        logic       rst;
        logic [7:0] row;
    } t_result;

    // Held trackball codes drift back toward rest on enabled ticks.
    function automatic logic [3:0] decay(input logic [3:0] h);
        logic [3:0] r;
        r = h;
        if (h >= 4'd1 && h <= 4'd8) begin
            r = h - 4'd1;
        end else if (h > 4'd9) begin
            r = h + 4'd1;
        end
        return r;
    endfunction

endpackage

// ===== rtl/biobtp_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module biobtp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 262144,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/biobtp_trk.sv =====
// Trackball delta to 4-bit code: clamp, floor shift, optional inversion, dead zone.
module biobtp_trk (
    input  logic signed [15:0] i_delta,
    input  logic               i_invert,
    output logic [3:0]         o_code
);

    logic signed [11:0] w_clamp;
    logic signed [11:0] w_shift;
    logic        [7:0]  w_byte;

    always_comb begin
        if (i_delta > 16'sd1024) begin
            w_clamp = 12'sd1024;
        end else if (i_delta < -16'sd1024) begin
            w_clamp = -12'sd1024;
        end else begin
            w_clamp = 12'(i_delta);
        end
        // An arithmetic shift gives the floor of the division by 16.
        w_shift = w_clamp >>> 4;
        w_byte  = i_invert ? ~w_shift[7:0] : w_shift[7:0];
        if (w_byte[7:4] == 4'hf || w_byte < 8'h10) begin
            o_code = 4'd0;
        end else begin
            o_code = w_byte[7:4];
        end
    end

endmodule

// ===== rtl/board_io_blitter_trackball_port.sv =====
// Top level of the board I/O blitter trackball port.
// Path: an accepted item enters the result stage (RAM read), then the output register that drives o_out_valid.
// Throughput: one item per cycle unless the output stalls; the graphics ROM sees at most one access per item.
// Input ready falls only while the result stage and output register are both full and stalled.
// Reset (synchronous, active low) clears the pointer, holds, watchdog, row and latch and restores
// the settings to their defaults; the graphics ROM keeps its contents, undefined until loaded.
module board_io_blitter_trackball_port #(
    parameter int ROM_ADDR_BITS = 18
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_req_type,
    input  logic [15:0] i_bus_address,
    input  logic [7:0]  i_write_data,
    input  logic [17:0] i_rom_load_address,
    input  logic signed [15:0] i_trackball_dx,
    input  logic signed [15:0] i_trackball_dy,
    input  logic [7:0]  i_port_zero_buttons,
    input  logic [7:0]  i_port_one_buttons,
    input  logic        i_frame_phase,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_read_data,
    output logic [7:0]  o_latch_value,
    output logic        o_sound_irq,
    output logic [2:0]  o_bank_index,
    output logic        o_bank_update,
    output logic        o_reset_request,
    output logic [7:0]  o_row_select
);
    import biobtp_pkg::*;

    localparam int ROM_DEPTH = 1 << ROM_ADDR_BITS;
    localparam logic [23:0] PTR_MASK = 24'((25'd1 << ROM_ADDR_BITS) - 25'd1);

    // Configuration.
    logic       r_variant;
    logic       r_cabinet;
    logic [7:0] r_wd_limit;

    // Architectural state.
    logic [23:0] r_blit_ptr, n_blit_ptr;
    logic [3:0]  r_hold_x, n_hold_x;
    logic [3:0]  r_hold_y, n_hold_y;
    logic [7:0]  r_wd_cnt, n_wd_cnt;
    logic [7:0]  r_row, n_row;
    logic [7:0]  r_latch, n_latch;

    // Result stage and output register.
    logic    r_s1_vld;
    t_result r_s1, n_s1;
    logic    r_out_vld;
    t_result r_out;
    logic [7:0] r_out_rd;

    logic        w_accept;
    logic        w_s1_move;
    logic        w_rom_re;
    logic        w_rom_we;
    logic [8:0]  w_wd_next;
    logic        w_wd_exp;
    logic [3:0]  w_code_x;
    logic [3:0]  w_code_y;
    logic [23:0] w_load_ext;
    logic [7:0]  w_ram_rd;
    logic [7:0]  w_rd_final;

    assign w_s1_move  = r_s1_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_s1_vld || w_s1_move;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_load_ext = 24'(i_rom_load_address);

    assign w_rom_re = w_accept && (i_req_type == REQ_READ)
                      && (i_bus_address == ADDR_ROM_FILL || i_bus_address == ADDR_ROM_INC);
    assign w_rom_we = w_accept && (i_req_type == REQ_LOAD);

    biobtp_ram #(
        .WIDTH (8),
        .DEPTH (ROM_DEPTH)
    ) u_rom (
        .i_clk   (i_clk),
        .i_we    (w_rom_we),
        .i_waddr (w_load_ext[ROM_ADDR_BITS-1:0]),
        .i_wdata (i_write_data),
        .i_re    (w_rom_re),
        .i_raddr (r_blit_ptr[ROM_ADDR_BITS-1:0]),
        .o_rdata (w_ram_rd)
    );

    biobtp_trk u_trk_x (
        .i_delta  (i_trackball_dx),
        .i_invert (1'b0),
        .o_code   (w_code_x)
    );

    biobtp_trk u_trk_y (
        .i_delta  (i_trackball_dy),
        .i_invert (1'b1),
        .o_code   (w_code_y)
    );

    assign w_wd_next = {1'b0, r_wd_cnt} + 9'd1;
    assign w_wd_exp  = w_wd_next > {1'b0, r_wd_limit};

    always_comb begin
        n_blit_ptr = r_blit_ptr;
        n_hold_x   = r_hold_x;
        n_hold_y   = r_hold_y;
        n_wd_cnt   = r_wd_cnt;
        n_row      = r_row;
        n_latch    = r_latch;
        n_s1       = '0;
        case (i_req_type)
            REQ_WRITE: begin
                case (i_bus_address)
                    ADDR_PTR_HI:  n_blit_ptr[23:16] = i_write_data;
                    ADDR_PTR_MID: n_blit_ptr[15:8]  = i_write_data;
                    ADDR_PTR_LO:  n_blit_ptr[7:0]   = i_write_data;
                    ADDR_ROW:     n_row = i_write_data;
                    ADDR_BANK: begin
                        if (!r_variant) begin
                            n_s1.bank    = {i_write_data[3:2], i_write_data[0]};
                            n_s1.bank_ok = 1'b1;
                        end
                    end
                    ADDR_LATCH: begin
                        n_latch  = i_write_data;
                        n_s1.irq = 1'b1;
                    end
                    ADDR_WDOG: begin
                        n_wd_cnt = '0;
                        n_hold_x = '0;
                        n_hold_y = '0;
                    end
                    default: ;
                endcase
            end
            REQ_READ: begin
                case (i_bus_address)
                    ADDR_ROM_FILL: n_s1.rd_src = RD_FILL;
                    ADDR_ROM_INC: begin
                        n_s1.rd_src = RD_ROM;
                        n_blit_ptr  = (r_blit_ptr + 24'd1) & PTR_MASK;
                    end
                    ADDR_PORT0: begin
                        if (w_code_y != 4'd0) begin
                            n_hold_y = w_code_y;
                        end
                        n_s1.rd_byte = (i_port_zero_buttons & P0_MASK)
                                     | {1'b0, r_cabinet, 6'd0}
                                     | {4'd0, (w_code_y != 4'd0) ? w_code_y : r_hold_y};
                    end
                    ADDR_PORT1: begin
                        if (w_code_x != 4'd0) begin
                            n_hold_x = w_code_x;
                        end
                        n_s1.rd_byte = (i_port_one_buttons & P1_MASK)
                                     | {4'd0, (w_code_x != 4'd0) ? w_code_x : r_hold_x};
                    end
                    default: ;
                endcase
            end
            REQ_TICK: begin
                if (w_wd_exp) begin
                    n_s1.rst   = 1'b1;
                    n_wd_cnt   = '0;
                    n_blit_ptr = '0;
                end else begin
                    n_wd_cnt = w_wd_next[7:0];
                end
                if (i_frame_phase) begin
                    n_hold_x = decay(r_hold_x);
                    n_hold_y = decay(r_hold_y);
                end
            end
            default: ;
        endcase
        n_s1.latch = n_latch;
        n_s1.row   = n_row;
    end

    // Final read byte: the ROM byte from the RAM's registered read port arrives as the item enters the result stage.
    always_comb begin
        case (r_s1.rd_src)
            RD_ROM:  w_rd_final = w_ram_rd;
            RD_FILL: begin
                w_rd_final = w_ram_rd;
                if (w_ram_rd[7:4] == 4'd0) begin
                    w_rd_final[7:4] = 4'hf;
                end
                if (w_ram_rd[3:0] == 4'd0) begin
                    w_rd_final[3:0] = 4'hf;
                end
            end
            default: w_rd_final = r_s1.rd_byte;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_variant  <= 1'b0;
            r_cabinet  <= 1'b1;
            r_wd_limit <= 8'd120;
            r_blit_ptr <= '0;
            r_hold_x   <= '0;
            r_hold_y   <= '0;
            r_wd_cnt   <= '0;
            r_row      <= '0;
            r_latch    <= '0;
            r_s1_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_VARIANT: r_variant  <= i_cfg_data[0];
                    CFG_CABINET: r_cabinet  <= i_cfg_data[0];
                    CFG_WDLIMIT: r_wd_limit <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_accept) begin
                r_blit_ptr <= n_blit_ptr;
                r_hold_x   <= n_hold_x;
                r_hold_y   <= n_hold_y;
                r_wd_cnt   <= n_wd_cnt;
                r_row      <= n_row;
                r_latch    <= n_latch;
            end
            if (w_accept) begin
                r_s1_vld <= 1'b1;
            end else if (w_s1_move) begin
                r_s1_vld <= 1'b0;
            end
            if (w_s1_move) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1 <= n_s1;
        end
        if (w_s1_move) begin
            r_out    <= r_s1;
            r_out_rd <= w_rd_final;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_read_data     = r_out_rd;
    assign o_latch_value   = r_out.latch;
    assign o_sound_irq     = r_out.irq;
    assign o_bank_index    = r_out.bank;
    assign o_bank_update   = r_out.bank_ok;
    assign o_reset_request = r_out.rst;
    assign o_row_select    = r_out.row;

    // An expiring tick leaves the pointer and the watchdog count cleared.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_req_type == REQ_TICK && w_wd_exp) |=> (r_blit_ptr == '0 && r_wd_cnt == '0))
        else $error("watchdog expiry did not clear pointer and count");

    // While a ROM read waits in the result stage, no new RAM read disturbs its byte.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !w_s1_move && r_s1.rd_src != RD_DIRECT) |=> $stable(w_ram_rd))
        else $error("ROM byte changed under a stalled result");

    // Every transfer in fills the result stage on the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_s1_vld)
        else $error("accepted item lost before the result stage");

    // A bank index is reported only when the board has banking.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_variant) |=> !r_s1.bank_ok)
        else $error("bank update on a board without banking");

endmodule

// ===== tb/board_io_blitter_trackball_port_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the board I/O blitter trackball port.
module board_io_blitter_trackball_port_test;
    import biobtp_pkg::*;

    localparam int          ROM_BITS   = 18;
    localparam int          ROM_DEPTH  = 1 << ROM_BITS;
    localparam logic [23:0] ROM_MASK   = 24'(ROM_DEPTH - 1);
    localparam logic [1:0]  CFG_UNUSED = 2'd3;
    localparam logic [15:0] ADDR_SPARE = 16'h1234;
    localparam logic [15:0] ADDR_VIDEO = 16'h5000;
    localparam int          LONG_HOLD  = 300;
    localparam int          PHASE_LEN  = 110;

    typedef struct {
        logic [1:0]         kind;
        logic [15:0]        addr;
        logic [7:0]         data;
        logic [17:0]        load_addr;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic [7:0]         p0;
        logic [7:0]         p1;
        logic               phase;
    } t_bus_req;

    typedef struct packed {
        logic [7:0] rd;
        logic [7:0] latch;
        logic       irq;
        logic [2:0] bank;
        logic       bank_ok;
        logic       rst;
        logic [7:0] row;
    } t_port_res;

    typedef struct {
        t_bus_req  rq;
        t_port_res want;
    } t_pending;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_idx = '0;
    logic [7:0]         i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [1:0]         i_req_type = '0;
    logic [15:0]        i_bus_address = '0;
    logic [7:0]         i_write_data = '0;
    logic [17:0]        i_rom_load_address = '0;
    logic signed [15:0] i_trackball_dx = '0;
    logic signed [15:0] i_trackball_dy = '0;
    logic [7:0]         i_port_zero_buttons = '0;
    logic [7:0]         i_port_one_buttons = '0;
    logic               i_frame_phase = 1'b0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [7:0]         o_read_data;
    logic [7:0]         o_latch_value;
    logic               o_sound_irq;
    logic [2:0]         o_bank_index;
    logic               o_bank_update;
    logic               o_reset_request;
    logic [7:0]         o_row_select;

    board_io_blitter_trackball_port #(
        .ROM_ADDR_BITS(ROM_BITS)
    ) u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_req_type         (i_req_type),
        .i_bus_address      (i_bus_address),
        .i_write_data       (i_write_data),
        .i_rom_load_address (i_rom_load_address),
        .i_trackball_dx     (i_trackball_dx),
        .i_trackball_dy     (i_trackball_dy),
        .i_port_zero_buttons(i_port_zero_buttons),
        .i_port_one_buttons (i_port_one_buttons),
        .i_frame_phase      (i_frame_phase),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_read_data        (o_read_data),
        .o_latch_value      (o_latch_value),
        .o_sound_irq        (o_sound_irq),
        .o_bank_index       (o_bank_index),
        .o_bank_update      (o_bank_update),
        .o_reset_request    (o_reset_request),
        .o_row_select       (o_row_select)
    );

    // Shadow copy of the block state and its settings.
    logic [7:0]  rom_img [0:ROM_DEPTH-1];
    bit          rom_ok  [0:ROM_DEPTH-1];
    logic [23:0] ptr = '0;
    logic [3:0]  hold_x = '0;
    logic [3:0]  hold_y = '0;
    logic [7:0]  wd_cnt = '0;
    logic [7:0]  row_reg = '0;
    logic [7:0]  latch_reg = '0;
    logic        cfg_variant = 1'b0;
    logic        cfg_cabinet = 1'b1;
    logic [7:0]  cfg_wd_limit = 8'd120;

    t_pending  pend_q[$];
    t_port_res expect_q[$];
    t_port_res drv_want;
    logic      in_fire = 1'b0;

    int n_queued = 0;
    int n_checked = 0;
    int n_fail = 0;
    int n_rom_reads = 0;
    int n_port_reads = 0;
    int n_wd_resets = 0;
    int n_cfg = 0;
    int drv_gap = 0;
    int drv_calm = 0;
    int rcv_hold = 0;
    int rcv_calm = 0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("[board_io_blitter_trackball_port] ERROR");
        $finish;
    end

    function automatic logic [7:0] scale_motion(input logic signed [15:0] v);
        int c;
        int q;
        c = v;
        if (c > 1024) c = 1024;
        if (c < -1024) c = -1024;
        q = c >>> 4;
        return q[7:0];
    endfunction

    // A byte in the top or bottom band counts as no motion.
    function automatic logic [3:0] motion_code(input logic [7:0] b);
        if (b[7:4] == 4'hf || b < 8'h10) return 4'd0;
        return b[7:4];
    endfunction

    function automatic logic [3:0] drift_hold(input logic [3:0] h);
        if (h >= 4'd1 && h <= 4'd8) return h - 4'd1;
        if (h > 4'd9) return (h == 4'd15) ? 4'd0 : h + 4'd1;
        return h;
    endfunction

    function automatic t_port_res predict_port(input t_bus_req rq);
        t_port_res  r;
        logic [3:0] c;
        logic [8:0] next_cnt;
        r = '0;
        case (rq.kind)
            REQ_WRITE: begin
                case (rq.addr)
                    ADDR_PTR_HI:  ptr[23:16] = rq.data;
                    ADDR_PTR_MID: ptr[15:8] = rq.data;
                    ADDR_PTR_LO:  ptr[7:0] = rq.data;
                    ADDR_ROW:     row_reg = rq.data;
                    ADDR_BANK: begin
                        if (!cfg_variant) begin
                            r.bank = {rq.data[3:2], rq.data[0]};
                            r.bank_ok = 1'b1;
                        end
                    end
                    ADDR_LATCH: begin
                        latch_reg = rq.data;
                        r.irq = 1'b1;
                    end
                    ADDR_WDOG: begin
                        wd_cnt = '0;
                        hold_x = '0;
                        hold_y = '0;
                    end
                    default: ;
                endcase
            end
            REQ_READ: begin
                case (rq.addr)
                    ADDR_ROM_FILL: begin
                        r.rd = rom_img[ptr & ROM_MASK];
                        if (r.rd[7:4] == 4'h0) r.rd[7:4] = 4'hf;
                        if (r.rd[3:0] == 4'h0) r.rd[3:0] = 4'hf;
                    end
                    ADDR_ROM_INC: begin
                        r.rd = rom_img[ptr & ROM_MASK];
                        ptr = (ptr + 24'd1) & ROM_MASK;
                    end
                    ADDR_PORT0: begin
                        c = motion_code(8'hff - scale_motion(rq.dy));
                        if (c != 4'd0) hold_y = c;
                        r.rd = (rq.p0 & P0_MASK) | {1'b0, cfg_cabinet, 6'd0} | {4'd0, hold_y};
                    end
                    ADDR_PORT1: begin
                        c = motion_code(scale_motion(rq.dx));
                        if (c != 4'd0) hold_x = c;
                        r.rd = (rq.p1 & P1_MASK) | {4'd0, hold_x};
                    end
                    default: ;
                endcase
            end
            REQ_TICK: begin
                next_cnt = {1'b0, wd_cnt} + 9'd1;
                if (next_cnt > {1'b0, cfg_wd_limit}) begin
                    r.rst = 1'b1;
                    wd_cnt = '0;
                    ptr = '0;
                end else begin
                    wd_cnt = next_cnt[7:0];
                end
                if (rq.phase) begin
                    hold_y = drift_hold(hold_y);
                    hold_x = drift_hold(hold_x);
                end
            end
            default: begin
                rom_img[rq.load_addr] = rq.data;
                rom_ok[rq.load_addr] = 1'b1;
            end
        endcase
        r.latch = latch_reg;
        r.row = row_reg;
        return r;
    endfunction

    function automatic logic signed [15:0] rand_motion();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom);
            1:       return 16'(int'($urandom_range(0, 600)) - 300);
            default: return 16'(int'($urandom_range(0, 2400)) - 1200);
        endcase
    endfunction

    function automatic t_bus_req rand_req();
        t_bus_req rq;
        rq.kind = 2'($urandom_range(0, 3));
        rq.addr = 16'($urandom);
        rq.data = 8'($urandom);
        rq.load_addr = 18'($urandom);
        rq.dx = rand_motion();
        rq.dy = rand_motion();
        rq.p0 = 8'($urandom);
        rq.p1 = 8'($urandom);
        rq.phase = 1'($urandom);
        return rq;
    endfunction

    // A ROM read of a never-loaded entry is avoided by loading that entry first.
    task automatic queue_item(input t_bus_req rq);
        t_pending p;
        t_bus_req ld;
        if (rq.kind == REQ_READ && (rq.addr == ADDR_ROM_FILL || rq.addr == ADDR_ROM_INC)) begin
            if (!rom_ok[ptr & ROM_MASK]) begin
                ld = rand_req();
                ld.kind = REQ_LOAD;
                ld.load_addr = 18'(ptr & ROM_MASK);
                queue_item(ld);
            end
            n_rom_reads++;
        end
        if (rq.kind == REQ_READ && (rq.addr == ADDR_PORT0 || rq.addr == ADDR_PORT1)) begin
            n_port_reads++;
        end
        p.rq = rq;
        p.want = predict_port(rq);
        if (p.want.rst) n_wd_resets++;
        pend_q.push_back(p);
        n_queued++;
    endtask

    task automatic send_op(input logic [1:0] k, input logic [15:0] a, input logic [7:0] d);
        t_bus_req rq;
        rq = rand_req();
        rq.kind = k;
        rq.addr = a;
        rq.data = d;
        queue_item(rq);
    endtask

    task automatic send_load(input logic [17:0] a, input logic [7:0] d);
        t_bus_req rq;
        rq = rand_req();
        rq.kind = REQ_LOAD;
        rq.load_addr = a;
        rq.data = d;
        queue_item(rq);
    endtask

    task automatic send_motion(input logic [15:0] a, input logic signed [15:0] dx,
                               input logic signed [15:0] dy);
        t_bus_req rq;
        rq = rand_req();
        rq.kind = REQ_READ;
        rq.addr = a;
        rq.dx = dx;
        rq.dy = dy;
        queue_item(rq);
    endtask

    task automatic add_traffic();
        t_bus_req    rq;
        int          r;
        int          n;
        logic [7:0]  d;
        r = $urandom_range(0, 99);
        rq = rand_req();
        if (r < 12) begin
            // Typical blitter use: set the pointer, load a few bytes, stream them back.
            n = $urandom_range(1, 6);
            send_op(REQ_WRITE, ADDR_PTR_HI, 8'($urandom));
            send_op(REQ_WRITE, ADDR_PTR_MID, 8'($urandom));
            send_op(REQ_WRITE, ADDR_PTR_LO, 8'($urandom));
            for (int i = 0; i < n; i++) begin
                d = 8'($urandom);
                case ($urandom_range(0, 3))
                    0: d = d & 8'h0f;
                    1: d = d & 8'hf0;
                    default: ;
                endcase
                send_load(18'((ptr + 24'(i)) & ROM_MASK), d);
            end
            for (int i = 0; i < n; i++) begin
                send_op(REQ_READ, ($urandom_range(0, 4) == 0) ? ADDR_ROM_FILL : ADDR_ROM_INC,
                        8'($urandom));
            end
        end else if (r < 20) begin
            rq.kind = REQ_READ;
            rq.addr = $urandom_range(0, 1) ? ADDR_ROM_FILL : ADDR_ROM_INC;
            queue_item(rq);
        end else if (r < 28) begin
            rq.kind = REQ_LOAD;
            queue_item(rq);
        end else if (r < 50) begin
            rq.kind = REQ_READ;
            rq.addr = $urandom_range(0, 1) ? ADDR_PORT0 : ADDR_PORT1;
            queue_item(rq);
        end else if (r < 62) begin
            rq.kind = REQ_TICK;
            queue_item(rq);
        end else if (r < 72) begin
            rq.kind = REQ_WRITE;
            case ($urandom_range(0, 2))
                0:       rq.addr = ADDR_PTR_HI;
                1:       rq.addr = ADDR_PTR_MID;
                default: rq.addr = ADDR_PTR_LO;
            endcase
            queue_item(rq);
        end else if (r < 84) begin
            rq.kind = REQ_WRITE;
            case ($urandom_range(0, 2))
                0:       rq.addr = ADDR_ROW;
                1:       rq.addr = ADDR_BANK;
                default: rq.addr = ADDR_LATCH;
            endcase
            queue_item(rq);
        end else if (r < 88) begin
            rq.kind = REQ_WRITE;
            rq.addr = ADDR_WDOG;
            queue_item(rq);
        end else if (r < 94) begin
            rq.kind = $urandom_range(0, 1) ? REQ_WRITE : REQ_READ;
            queue_item(rq);
        end else begin
            queue_item(rq);
        end
    endtask

    task automatic run_traffic(input int count);
        int start;
        start = n_queued;
        while (n_queued - start < count) add_traffic();
    endtask

    task automatic wait_idle();
        while (n_checked != n_queued) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_setting(input logic [1:0] idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_VARIANT: cfg_variant = val[0];
            CFG_CABINET: cfg_cabinet = val[0];
            CFG_WDLIMIT: cfg_wd_limit = val;
            default: ;
        endcase
        n_cfg++;
    endtask

    // Sender: the payload stays put until the transfer completes.
    always @(negedge i_clk) begin : drive_items
        t_pending p;
        int       r;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_fire) begin
        end else if (drv_gap > 0) begin
            drv_gap--;
            i_in_valid <= 1'b0;
        end else if (pend_q.size() > 0) begin
            p = pend_q.pop_front();
            i_req_type <= p.rq.kind;
            i_bus_address <= p.rq.addr;
            i_write_data <= p.rq.data;
            i_rom_load_address <= p.rq.load_addr;
            i_trackball_dx <= p.rq.dx;
            i_trackball_dy <= p.rq.dy;
            i_port_zero_buttons <= p.rq.p0;
            i_port_one_buttons <= p.rq.p1;
            i_frame_phase <= p.rq.phase;
            drv_want <= p.want;
            i_in_valid <= 1'b1;
            if (drv_calm > 0) begin
                drv_calm--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 3) drv_calm = $urandom_range(20, 80);
                else if (r < 55) drv_gap = 0;
                else if (r < 85) drv_gap = $urandom_range(1, 3);
                else if (r < 97) drv_gap = $urandom_range(4, 10);
                else drv_gap = $urandom_range(20, 60);
            end
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    always @(negedge i_clk) begin : drive_ready
        int r;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (rcv_hold > 0) begin
            rcv_hold--;
            i_out_ready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            // One long hold-off so that the block backs up and drops its input ready.
            hold_done = 1'b1;
            rcv_hold = LONG_HOLD - 1;
            i_out_ready <= 1'b0;
        end else if (rcv_calm > 0) begin
            rcv_calm--;
            i_out_ready <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                rcv_calm = $urandom_range(20, 80);
                i_out_ready <= 1'b1;
            end else if (r < 65) begin
                i_out_ready <= 1'b1;
            end else if (r < 95) begin
                i_out_ready <= 1'b0;
            end else begin
                rcv_hold = $urandom_range(10, 40);
                i_out_ready <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_port_res want;
        in_fire <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready) expect_q.push_back(drv_want);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expect_q.size() == 0) begin
                $error("result transfer with no item outstanding");
                n_fail++;
            end else begin
                want = expect_q.pop_front();
                n_checked++;
                if (o_read_data !== want.rd) begin
                    $error("read_data: expected %h, got %h", want.rd, o_read_data);
                    n_fail++;
                end
                if (o_latch_value !== want.latch) begin
                    $error("latch_value: expected %h, got %h", want.latch, o_latch_value);
                    n_fail++;
                end
                if (o_sound_irq !== want.irq) begin
                    $error("sound_irq: expected %b, got %b", want.irq, o_sound_irq);
                    n_fail++;
                end
                if (o_bank_index !== want.bank) begin
                    $error("bank_index: expected %0d, got %0d", want.bank, o_bank_index);
                    n_fail++;
                end
                if (o_bank_update !== want.bank_ok) begin
                    $error("bank_update: expected %b, got %b", want.bank_ok, o_bank_update);
                    n_fail++;
                end
                if (o_reset_request !== want.rst) begin
                    $error("reset_request: expected %b, got %b", want.rst, o_reset_request);
                    n_fail++;
                end
                if (o_row_select !== want.row) begin
                    $error("row_select: expected %h, got %h", want.row, o_row_select);
                    n_fail++;
                end
            end
        end
    end

    initial begin : stimulus
        t_bus_req rq;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Pointer at all ones: the ROM address masks down and the auto-increment wraps.
        send_op(REQ_WRITE, ADDR_PTR_HI, 8'hff);
        send_op(REQ_WRITE, ADDR_PTR_MID, 8'hff);
        send_op(REQ_WRITE, ADDR_PTR_LO, 8'hff);
        send_load(18'h3ffff, 8'h00);
        send_op(REQ_READ, ADDR_ROM_FILL, 8'h00);
        send_op(REQ_READ, ADDR_ROM_INC, 8'h00);
        // Nibble fill with an empty low nibble, then with an empty high nibble.
        send_load(18'h00000, 8'h50);
        send_op(REQ_READ, ADDR_ROM_FILL, 8'hff);
        send_load(18'h00000, 8'h05);
        send_op(REQ_READ, ADDR_ROM_FILL, 8'h00);
        send_op(REQ_READ, ADDR_ROM_INC, 8'hff);
        send_op(REQ_WRITE, ADDR_ROW, 8'ha5);
        send_op(REQ_WRITE, ADDR_LATCH, 8'h3c);
        send_op(REQ_WRITE, ADDR_BANK, 8'hff);
        // Clamped extremes, then the dead zone returning the held codes, then one more clamped extreme.
        send_motion(ADDR_PORT1, 16'sh7fff, 16'sh0000);
        send_motion(ADDR_PORT0, 16'sh0000, 16'sh8000);
        send_motion(ADDR_PORT1, -16'sd16, 16'sh0000);
        send_motion(ADDR_PORT0, 16'sh0000, 16'sh0000);
        send_motion(ADDR_PORT1, -16'sd1024, 16'sh0000);
        rq = rand_req();
        rq.kind = REQ_TICK;
        rq.phase = 1'b1;
        queue_item(rq);
        send_op(REQ_WRITE, ADDR_WDOG, 8'h00);
        send_op(REQ_WRITE, ADDR_SPARE, 8'h77);
        send_op(REQ_READ, ADDR_VIDEO, 8'h00);
        send_op(REQ_READ, ADDR_WDOG, 8'h00);
        wait_idle();

        hold_req = 1'b1;
        run_traffic(PHASE_LEN);
        wait_idle();

        write_setting(CFG_VARIANT, 8'd1);
        write_setting(CFG_CABINET, 8'd0);
        write_setting(CFG_WDLIMIT, 8'd255);
        run_traffic(PHASE_LEN);
        wait_idle();

        write_setting(CFG_VARIANT, 8'd0);
        write_setting(CFG_WDLIMIT, 8'd3);
        run_traffic(PHASE_LEN);
        wait_idle();

        // An index past the register list must change nothing.
        write_setting(CFG_UNUSED, 8'hff);
        write_setting(CFG_WDLIMIT, 8'd0);
        write_setting(CFG_CABINET, 8'd1);
        write_setting(CFG_VARIANT, 8'd1);
        run_traffic(PHASE_LEN);
        wait_idle();

        write_setting(CFG_WDLIMIT, 8'd1);
        write_setting(CFG_VARIANT, 8'd0);
        run_traffic(PHASE_LEN);
        wait_idle();

        repeat (10) @(negedge i_clk);
        if (expect_q.size() != 0) begin
            $error("%0d results never arrived", expect_q.size());
            n_fail++;
        end
        $display("Checked %0d of %0d items across %0d setting writes.", n_checked, n_queued,
                 n_cfg);
        $display("Traffic held %0d ROM reads, %0d port reads and %0d watchdog resets.",
                 n_rom_reads, n_port_reads, n_wd_resets);
        if (n_fail == 0) begin
            $display("[board_io_blitter_trackball_port] OK");
        end else begin
            $display("[board_io_blitter_trackball_port] ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/biobtp_pkg.sv
rtl/biobtp_ram.sv
rtl/biobtp_trk.sv
rtl/board_io_blitter_trackball_port.sv
tb/board_io_blitter_trackball_port_test.sv
